>>> sv/hrfc_pkg.sv
// Shared types and constants for the Horn-rule forward chainer.
// No dependencies; imported by every module of the block.
package hrfc_pkg;

    localparam int PREM_W        = 26;   // s_premise_mask width
    localparam int LETTER_W      = 5;    // s_letter width
    localparam int FACTS_W       = 26;   // m_facts width
    localparam int STATUS_W      = 2;    // m_status width
    localparam int RULES_HELD_W  = 7;    // m_rules_held width

    localparam int DEF_MAX_RULES = 64;
    localparam int DEF_NUM_PROPS = 26;
    localparam int QUEUE_DEPTH   = 2;

    localparam int CMD_W         = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_FACT,       // add a fact, letter in range
        CMD_NOP,        // fact letter out of range, nothing to store
        CMD_RULE,       // store a rule (may still hit a full store)
        CMD_BAD_RULE    // conclusion among its own premises
    } cmd_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK,
        STAT_DUP_FACT,
        STAT_SELF_REF,
        STAT_FULL
    } status_t;

    localparam logic FUNC_ADD_RULE = 1'b0;
    localparam logic FUNC_ADD_FACT = 1'b1;

endpackage

>>> sv/horn_rule_forward_chainer.sv
// Top level of the Horn-rule forward chainer: front end, command queue, engine.
// Depends on hrfc_pkg, hrfc_front, hrfc_queue and hrfc_engine.
//
// Usage:
//   Input channel (s_valid/s_ready): one transaction adds a rule
//   (s_func = 0: s_premise_mask, conclusion s_letter) or a fact (s_func = 1).
//   Result channel (m_valid/m_ready): one transaction per input, carrying the
//   closed fact set, a status code and the number of stored rules.
//   Processing time per item grows with the number of stored rules R and the
//   number of scan passes P (at most NUM_PROPS + 1, since every pass but the
//   last adds a fact). It is set by the single-port rule memory, read one rule
//   per cycle by the scan loop; items are processed one at a time.
//   A two-entry command queue takes new inputs while the engine is busy.
//   If the receiver stalls, the finished result waits in the output register
//   and the engine holds its next result until that register frees.
//   Reset (aresetn low, synchronous) clears the fact set, the rule count, the
//   queue and the output valid; rule memory contents are left as they are
//   and are only read below the rule count.
module horn_rule_forward_chainer #(
    parameter int MAX_RULES = hrfc_pkg::DEF_MAX_RULES,
    parameter int NUM_PROPS = hrfc_pkg::DEF_NUM_PROPS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic [hrfc_pkg::PREM_W-1:0]         s_premise_mask,
    input  logic [hrfc_pkg::LETTER_W-1:0]       s_letter,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [hrfc_pkg::FACTS_W-1:0]        m_facts,
    output logic [hrfc_pkg::STATUS_W-1:0]       m_status,
    output logic [hrfc_pkg::RULES_HELD_W-1:0]   m_rules_held
);
    import hrfc_pkg::*;

    localparam int LW     = $clog2(NUM_PROPS);
    localparam int CMD_DW = CMD_W + NUM_PROPS + LW;

    logic              push_valid, push_ready;
    logic [CMD_DW-1:0] push_data;
    logic              pop_valid, pop_ready;
    logic [CMD_DW-1:0] pop_data;

    hrfc_front #(
        .NUM_PROPS (NUM_PROPS),
        .LW        (LW),
        .CMD_DW    (CMD_DW)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_premise_mask (s_premise_mask),
        .s_letter       (s_letter),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    hrfc_queue #(
        .W     (CMD_DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    hrfc_engine #(
        .MAX_RULES (MAX_RULES),
        .NUM_PROPS (NUM_PROPS),
        .LW        (LW),
        .CMD_DW    (CMD_DW)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (pop_valid),
        .cmd_ready    (pop_ready),
        .cmd_data     (pop_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_facts      (m_facts),
        .m_status     (m_status),
        .m_rules_held (m_rules_held)
    );

    // rule count reported can never pass the store size
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_rules_held) <= MAX_RULES)
        else $error("rules_held above store size");

    // a full-store status only when the store really is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_FULL) |-> m_rules_held == RULES_HELD_W'(MAX_RULES))
        else $error("store-full status with free rule slots");

    // no result transaction is pending right out of reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

>>> sv/hrfc_front.sv
// Front end: accepts input transactions, classifies them and packs a command.
// Depends on hrfc_pkg.
module hrfc_front #(
    parameter int NUM_PROPS = hrfc_pkg::DEF_NUM_PROPS,
    parameter int LW        = $clog2(NUM_PROPS),
    parameter int CMD_DW    = hrfc_pkg::CMD_W + NUM_PROPS + LW
) (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [hrfc_pkg::PREM_W-1:0]   s_premise_mask,
    input  logic [hrfc_pkg::LETTER_W-1:0] s_letter,
    output logic                          push_valid,
    input  logic                          push_ready,
    output logic [CMD_DW-1:0]             push_data
);
    import hrfc_pkg::*;

    logic [NUM_PROPS+PREM_W-1:0] prem_wide;
    logic [NUM_PROPS-1:0]        prem;
    logic [LW+LETTER_W-1:0]      letter_wide;
    logic [LW-1:0]               concl;
    logic                        letter_ok;
    logic                        self_ref;
    logic [NUM_PROPS-1:0]        prem_shifted;
    cmd_kind_t                   kind;
    logic [NUM_PROPS-1:0]        prem_store;

    // premise bits at or above NUM_PROPS drop out here
    assign prem_wide    = {{NUM_PROPS{1'b0}}, s_premise_mask};
    assign prem         = prem_wide[NUM_PROPS-1:0];
    assign letter_wide  = {{LW{1'b0}}, s_letter};
    assign concl        = letter_wide[LW-1:0];
    assign letter_ok    = 32'(s_letter) < NUM_PROPS;
    assign prem_shifted = prem >> s_letter;
    assign self_ref     = letter_ok && prem_shifted[0];

    always_comb begin
        prem_store = '0;
        if (s_func == FUNC_ADD_FACT) begin
            kind = letter_ok ? CMD_FACT : CMD_NOP;
        end else if (self_ref) begin
            kind = CMD_BAD_RULE;
        end else begin
            kind = CMD_RULE;
            // out-of-range conclusion: store an empty premise so it never fires
            if (letter_ok) begin
                prem_store = prem;
            end
        end
    end

    assign push_valid = s_valid;
    assign s_ready    = push_ready;
    assign push_data  = {kind, prem_store, concl};

endmodule

>>> sv/hrfc_queue.sv
// Short command queue between the front end and the inference engine.
// Depends on hrfc_pkg for the default depth.
module hrfc_queue #(
    parameter int W     = 8,
    parameter int DEPTH = hrfc_pkg::QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);
    import hrfc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/hrfc_engine.sv
// Inference engine: applies commands, holds the rule memory and fact set,
// and scans the rules to a fixpoint one rule per cycle. Depends on hrfc_pkg.
module hrfc_engine #(
    parameter int MAX_RULES = hrfc_pkg::DEF_MAX_RULES,
    parameter int NUM_PROPS = hrfc_pkg::DEF_NUM_PROPS,
    parameter int LW        = $clog2(NUM_PROPS),
    parameter int CMD_DW    = hrfc_pkg::CMD_W + NUM_PROPS + LW
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  logic [CMD_DW-1:0]                   cmd_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [hrfc_pkg::FACTS_W-1:0]        m_facts,
    output logic [hrfc_pkg::STATUS_W-1:0]       m_status,
    output logic [hrfc_pkg::RULES_HELD_W-1:0]   m_rules_held
);
    import hrfc_pkg::*;

    localparam int AW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int RCW = $clog2(MAX_RULES + 1);
    localparam int MW  = NUM_PROPS + LW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t               state_reg;
    status_t              status_reg;
    logic [NUM_PROPS-1:0] fact_set_reg;
    logic [RCW-1:0]       rule_total_reg;
    logic [RCW-1:0]       issue_reg;
    logic                 rd_valid_reg;
    logic                 changed_reg;
    logic [MW-1:0]        rd_data_reg;
    logic                 m_valid_reg;
    logic [FACTS_W-1:0]   m_facts_reg;
    status_t              m_status_reg;
    logic [RULES_HELD_W-1:0] m_rules_held_reg;

    logic [MW-1:0]        rule_mem [MAX_RULES];

    cmd_kind_t            cmd_kind;
    logic [NUM_PROPS-1:0] cmd_prem;
    logic [LW-1:0]        cmd_concl;
    logic                 store_full;
    logic                 do_store;
    logic                 issue_more;
    logic [NUM_PROPS-1:0] rd_prem;
    logic [LW-1:0]        rd_concl;
    logic                 fire;
    logic [NUM_PROPS+FACTS_W-1:0]  facts_wide;
    logic [RCW+RULES_HELD_W-1:0]   total_wide;

    assign cmd_kind   = cmd_kind_t'(cmd_data[CMD_DW-1 -: CMD_W]);
    assign cmd_prem   = cmd_data[MW-1:LW];
    assign cmd_concl  = cmd_data[LW-1:0];
    assign store_full = 32'(rule_total_reg) >= MAX_RULES;
    assign cmd_ready  = state_reg == ST_IDLE;
    assign do_store   = cmd_ready && cmd_valid && cmd_kind == CMD_RULE && !store_full;
    assign issue_more = issue_reg < rule_total_reg;

    assign rd_prem  = rd_data_reg[MW-1:LW];
    assign rd_concl = rd_data_reg[LW-1:0];
    // an empty premise never fires; stored out-of-range conclusions have one
    assign fire = (rd_prem != '0) && !fact_set_reg[rd_concl]
                  && ((rd_prem & fact_set_reg) == rd_prem);

    assign facts_wide = {{FACTS_W{1'b0}}, fact_set_reg};
    assign total_wide = {{RULES_HELD_W{1'b0}}, rule_total_reg};

    always_ff @(posedge aclk) begin
        if (do_store) begin
            rule_mem[rule_total_reg[AW-1:0]] <= {cmd_prem, cmd_concl};
        end
        if (state_reg == ST_SCAN && issue_more) begin
            rd_data_reg <= rule_mem[issue_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            status_reg       <= STAT_OK;
            fact_set_reg     <= '0;
            rule_total_reg   <= '0;
            issue_reg        <= '0;
            rd_valid_reg     <= 1'b0;
            changed_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
            m_facts_reg      <= '0;
            m_status_reg     <= STAT_OK;
            m_rules_held_reg <= '0;
        end else begin
            // in ST_FINISH the output register is either held or reloaded below
            if (m_ready && state_reg != ST_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        case (cmd_kind)
                            CMD_FACT: begin
                                if (fact_set_reg[cmd_concl]) begin
                                    status_reg <= STAT_DUP_FACT;
                                end else begin
                                    fact_set_reg[cmd_concl] <= 1'b1;
                                    status_reg              <= STAT_OK;
                                end
                            end
                            CMD_RULE: begin
                                if (store_full) begin
                                    status_reg <= STAT_FULL;
                                end else begin
                                    rule_total_reg <= rule_total_reg + 1'b1;
                                    status_reg     <= STAT_OK;
                                end
                            end
                            CMD_BAD_RULE: status_reg <= STAT_SELF_REF;
                            default:      status_reg <= STAT_OK;
                        endcase
                        issue_reg    <= '0;
                        rd_valid_reg <= 1'b0;
                        changed_reg  <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    rd_valid_reg <= issue_more;
                    if (issue_more) begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    if (rd_valid_reg && fire) begin
                        fact_set_reg[rd_concl] <= 1'b1;
                        changed_reg            <= 1'b1;
                    end
                    // pass complete once every issued read has been evaluated
                    if (!issue_more && !rd_valid_reg) begin
                        if (changed_reg) begin
                            issue_reg   <= '0;
                            changed_reg <= 1'b0;
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_facts_reg      <= facts_wide[FACTS_W-1:0];
                        m_status_reg     <= status_reg;
                        m_rules_held_reg <= total_wide[RULES_HELD_W-1:0];
                        state_reg        <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_facts      = m_facts_reg;
    assign m_status     = m_status_reg;
    assign m_rules_held = m_rules_held_reg;

endmodule

>>> test/tb_horn_rule_forward_chainer.sv
// Testbench for horn_rule_forward_chainer: directed and random rule/fact traffic,
// results checked against an in-bench closure predictor. Depends on hrfc_pkg
// and the horn_rule_forward_chainer RTL.
module tb_horn_rule_forward_chainer;
    import hrfc_pkg::*;

    localparam int MAX_RULES        = DEF_MAX_RULES;
    localparam int NUM_PROPS        = DEF_NUM_PROPS;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 2000;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        logic [FACTS_W-1:0]      facts;
        status_t                 status;
        logic [RULES_HELD_W-1:0] rules_held;
    } closure_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_func;
    logic [PREM_W-1:0]       s_premise_mask;
    logic [LETTER_W-1:0]     s_letter;
    logic                    m_valid;
    logic                    m_ready;
    logic [FACTS_W-1:0]      m_facts;
    logic [STATUS_W-1:0]     m_status;
    logic [RULES_HELD_W-1:0] m_rules_held;

    // knowledge base as the block should hold it
    logic [PREM_W-1:0]   kb_premise [MAX_RULES];
    logic [LETTER_W-1:0] kb_conclusion [MAX_RULES];
    int                  kb_count;
    logic [FACTS_W-1:0]  kb_facts;

    closure_t closure_q[$];
    int       fail_count;
    int       sink_hold_req;
    bit       steady_flow;

    horn_rule_forward_chainer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_premise_mask (s_premise_mask),
        .s_letter       (s_letter),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_facts        (m_facts),
        .m_status       (m_status),
        .m_rules_held   (m_rules_held)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Apply one item to the knowledge base, then fire rules until nothing changes.
    function automatic closure_t add_and_close(input logic func,
                                               input logic [PREM_W-1:0] prem,
                                               input logic [LETTER_W-1:0] letter);
        closure_t res;
        status_t  st;
        bit       changed;
        st = STAT_OK;
        if (func == FUNC_ADD_FACT) begin
            if (letter < NUM_PROPS) begin
                if (kb_facts[letter])
                    st = STAT_DUP_FACT;
                else
                    kb_facts[letter] = 1'b1;
            end
        end else if (letter < NUM_PROPS && prem[letter]) begin
            st = STAT_SELF_REF;
        end else if (kb_count >= MAX_RULES) begin
            st = STAT_FULL;
        end else begin
            kb_premise[kb_count]    = prem;
            kb_conclusion[kb_count] = letter;
            kb_count++;
        end
        changed = 1'b1;
        while (changed) begin
            changed = 1'b0;
            for (int r = 0; r < kb_count; r++) begin
                // empty premise or out-of-range conclusion never fires
                if (kb_premise[r] != '0 && kb_conclusion[r] < NUM_PROPS &&
                    !kb_facts[kb_conclusion[r]] &&
                    (kb_premise[r] & kb_facts) == kb_premise[r]) begin
                    kb_facts[kb_conclusion[r]] = 1'b1;
                    changed = 1'b1;
                end
            end
        end
        res.facts      = kb_facts;
        res.status     = st;
        res.rules_held = kb_count[RULES_HELD_W-1:0];
        return res;
    endfunction

    function automatic logic [PREM_W-1:0] prop_bit(input int k);
        logic [PREM_W-1:0] m;
        m    = '0;
        m[k] = 1'b1;
        return m;
    endfunction

    function automatic logic [PREM_W-1:0] few_premises();
        logic [PREM_W-1:0] m;
        int                n;
        m = '0;
        n = $urandom_range(1, 3);
        repeat (n) m[$urandom_range(0, NUM_PROPS - 1)] = 1'b1;
        return m;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, what);
    endtask

    // Offer one transaction; predict its result once it is taken.
    task automatic send_item(input logic func, input logic [PREM_W-1:0] prem,
                             input logic [LETTER_W-1:0] letter);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= func;
        s_premise_mask <= prem;
        s_letter       <= letter;
        do @(posedge aclk); while (!s_ready);
        closure_q.push_back(add_and_close(func, prem, letter));
    endtask

    task automatic send_random(input int fact_pct);
        int                  roll;
        logic [LETTER_W-1:0] letter;
        roll = $urandom_range(0, 99);
        if (roll < fact_pct) begin
            if ($urandom_range(0, 3) == 0)
                letter = LETTER_W'($urandom_range(NUM_PROPS, 31));
            else
                letter = LETTER_W'($urandom_range(0, NUM_PROPS - 1));
            send_item(FUNC_ADD_FACT, PREM_W'($urandom), letter);
        end else if (roll < fact_pct + 12) begin
            send_item(FUNC_ADD_RULE, PREM_W'($urandom), LETTER_W'($urandom_range(0, 31)));
        end else begin
            send_item(FUNC_ADD_RULE, few_premises(),
                      LETTER_W'($urandom_range(0, NUM_PROPS - 1)));
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (closure_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_item(FUNC_ADD_FACT, '0, 0);
        send_item(FUNC_ADD_FACT, '1, 0);                     // duplicate fact
        send_item(FUNC_ADD_FACT, '0, 31);                    // out-of-range fact
        send_item(FUNC_ADD_FACT, '0, 26);
        send_item(FUNC_ADD_RULE, prop_bit(0), 1);            // fires at once
        send_item(FUNC_ADD_RULE, prop_bit(2) | prop_bit(3), 4);
        send_item(FUNC_ADD_RULE, prop_bit(4), 5);
        send_item(FUNC_ADD_FACT, '0, 2);
        send_item(FUNC_ADD_FACT, '0, 3);                     // chain E then F
        send_item(FUNC_ADD_RULE, prop_bit(6) | prop_bit(7), 7); // self-referencing
        send_item(FUNC_ADD_RULE, '1, 25);
        send_item(FUNC_ADD_RULE, '0, 6);                     // empty premise
        send_item(FUNC_ADD_RULE, prop_bit(0), 31);           // conclusion out of range
        send_item(FUNC_ADD_RULE, '1, 26);
        send_item(FUNC_ADD_RULE, prop_bit(12), 13);
        send_item(FUNC_ADD_RULE, prop_bit(11), 12);
        send_item(FUNC_ADD_FACT, '0, 11);                    // needs a second pass
        send_item(FUNC_ADD_RULE, prop_bit(25), 24);
        send_item(FUNC_ADD_FACT, '0, 25);
        send_item(FUNC_ADD_RULE, prop_bit(25), 0);           // conclusion already known
        send_item(FUNC_ADD_FACT, '0, 24);                    // derived, so duplicate
        wait_drained();
    endtask

    // Result side stalls long while the source keeps pushing, filling the block.
    task automatic test_sink_backpressure();
        sink_hold_req = SINK_HOLD_CYCLES;
        steady_flow   = 1'b1;
        repeat (10) send_random(10);
        steady_flow = 1'b0;
        wait_drained();
    endtask

    task automatic test_rule_buildup();
        repeat (100) send_random(8);
        wait_drained();
    endtask

    task automatic test_store_full();
        while (kb_count < MAX_RULES)
            send_item(FUNC_ADD_RULE, few_premises(),
                      LETTER_W'($urandom_range(0, NUM_PROPS - 1)));
        send_item(FUNC_ADD_RULE, prop_bit(3), 9);
        send_item(FUNC_ADD_RULE, prop_bit(9), 9);            // self-ref wins over full
        send_item(FUNC_ADD_RULE, '0, 31);
        send_item(FUNC_ADD_FACT, '0, 17);
        wait_drained();
    endtask

    task automatic test_mixed_traffic();
        for (int i = 0; i < 215; i++) begin
            steady_flow = ((i / 20) % 3 == 1);
            send_random(25);
        end
        steady_flow = 1'b0;
        wait_drained();
    endtask

    // result-side ready: random gap per transaction, or one long hold on request
    initial begin : sink_ready_drive
        int gap;
        gap = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready)
                gap = steady_flow ? 0 : $urandom_range(0, 5);
            if (sink_hold_req > 0) begin
                gap           = sink_hold_req;
                sink_hold_req = 0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                gap--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        closure_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (closure_q.size() == 0) begin
                note_failure($sformatf("unexpected result facts=%h status=%0d rules=%0d",
                                       m_facts, m_status, m_rules_held));
            end else begin
                want = closure_q.pop_front();
                if (m_facts !== want.facts || m_status !== want.status ||
                    m_rules_held !== want.rules_held)
                    note_failure($sformatf(
                        "exp facts=%h status=%0d rules=%0d, got facts=%h status=%0d rules=%0d",
                        want.facts, want.status, want.rules_held,
                        m_facts, m_status, m_rules_held));
            end
        end
    end

    initial begin
        #24000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        fail_count     = 0;
        sink_hold_req  = 0;
        steady_flow    = 1'b0;
        kb_count       = 0;
        kb_facts       = '0;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_func         <= FUNC_ADD_RULE;
        s_premise_mask <= '0;
        s_letter       <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_sink_backpressure();
        test_rule_buildup();
        test_store_full();
        test_mixed_traffic();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (closure_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", closure_q.size()));
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
